/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

  localparam int NODES           = 4;
  localparam int GROUPS          = 16;
  localparam int WORDS_PER_GROUP = 64;
  localparam int WORD_W          = 64;

  localparam int NODE_W  = 2;
  localparam int GROUP_W = 4;
  localparam int WIDX_W  = 6;
  localparam int BIT_W   = 6;
  localparam int BLOCK_W = 16;
  localparam int BPN_W   = 17;
  localparam int NCNT_W  = 3;
  localparam int STAT_W  = 2;

  localparam int MAP_DEPTH = NODES * GROUPS * WORDS_PER_GROUP;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SUM_DEPTH = NODES * GROUPS;
  localparam int SUM_AW    = $clog2(SUM_DEPTH);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_BLOCKS     = 1'b1;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 3'd4;
  localparam logic [BPN_W-1:0]  BLOCKS_RST     = 17'd65536;

  typedef struct packed {
    logic              active;
    logic [MAP_AW-1:0] addr;
  } clr_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) n = BIT_W'(i);
    end
    return n;
  endfunction

  // n low bits set; n of 64 or more gives all ones
  function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W:0] n);
    logic [WORD_W-1:0] m;
    if (n[BIT_W]) m = '1;
    else          m = (WORD_W'(1) << n[BIT_W-1:0]) - WORD_W'(1);
    return m;
  endfunction

endpackage

/* rtl/bitmap_block_allocator_core.sv */
`timescale 1ns / 1ps

// Free-block bitmap allocator for up to four memory nodes.
// Input: an item is taken at a rising edge with start high and busy low.
// in_op selects allocate or free; allocate searches group in_group of
// node in_node, free returns block in_block of node in_node.
// Output: one result per item, held for a single cycle with out_valid high;
// the receiver has no way to stall it.
// Timing: a free, a rejected request or an allocate whose group summary
// shows no usable word gives its result from state S_SUM; an allocate
// that goes on to read a map word passes S_SUM and then S_WORD. The
// result is registered, and busy drops in the cycle it appears, so a new
// item is not taken before the last one is through.
// These steps come from the read-modify-write of the two single-port RAMs:
// a per-group summary (one bit per word, set while the word holds a free
// block) picks the word, then one map word is read and written back.
// Configuration: cfg_index 0 is the node count, 1 the usable blocks per
// node; cfg_ready is always high. Write only while idle.
// Reset: after rst_n releases, a clearing pass marks every block free,
// one map word per cycle through all 4096 map words; busy is high meanwhile.
module bitmap_block_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [bba_pkg::NODE_W-1:0]   in_node,
  input  logic [bba_pkg::GROUP_W-1:0]  in_group,
  input  logic [bba_pkg::BLOCK_W-1:0]  in_block,
  output logic                         out_valid,
  output logic [bba_pkg::STAT_W-1:0]   out_status,
  output logic [bba_pkg::NODE_W-1:0]   out_node,
  output logic [bba_pkg::BLOCK_W-1:0]  out_block,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [bba_pkg::BPN_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUM  = 3'b010,
    S_WORD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [bba_pkg::NCNT_W-1:0]  node_count_r;
  logic [bba_pkg::BPN_W-1:0]   bpn_r;

  logic                        op_r;
  logic                        bad_r;
  logic [bba_pkg::NODE_W-1:0]  node_r;
  logic [bba_pkg::GROUP_W-1:0] grp_r, grp_nxt;
  logic [bba_pkg::WIDX_W-1:0]  wrd_r, wrd_nxt;
  logic [bba_pkg::BIT_W-1:0]   bit_r;
  logic [bba_pkg::WORDS_PER_GROUP-1:0] sum_keep_r;

  logic                        out_valid_r;
  logic [bba_pkg::STAT_W-1:0]  out_status_r;
  logic [bba_pkg::NODE_W-1:0]  out_node_r;
  logic [bba_pkg::BLOCK_W-1:0] out_block_r;
  logic                        res_vld;
  logic [bba_pkg::STAT_W-1:0]  res_stat;
  logic [bba_pkg::BLOCK_W-1:0] res_block;

  bba_pkg::clr_t clr;

  logic                        map_we, sum_we;
  logic [bba_pkg::MAP_AW-1:0]  map_addr;
  logic [bba_pkg::SUM_AW-1:0]  sum_addr;
  logic [bba_pkg::WORD_W-1:0]  map_wdata, map_q;
  logic [bba_pkg::WORDS_PER_GROUP-1:0] sum_wdata, sum_q;

  logic                        accept;
  logic [bba_pkg::NCNT_W-1:0]  node_lim;
  logic                        node_ok;
  logic                        in_bad;

  logic [bba_pkg::BPN_W-1:0]   gbase, rem;
  logic [bba_pkg::BPN_W:0]     nw_full;
  logic [bba_pkg::WIDX_W:0]    nwords;
  logic [bba_pkg::WORDS_PER_GROUP-1:0] cand;

  logic [bba_pkg::BPN_W-1:0]   wbase, left;
  logic [bba_pkg::WORD_W-1:0]  umask, avail, alloc_word;
  logic [bba_pkg::BIT_W-1:0]   alloc_bit;

  bba_init u_init (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  bba_ram #(
    .WIDTH (bba_pkg::WORD_W),
    .DEPTH (bba_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_q)
  );

  bba_ram #(
    .WIDTH (bba_pkg::WORDS_PER_GROUP),
    .DEPTH (bba_pkg::SUM_DEPTH)
  ) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .addr  (sum_addr),
    .wdata (sum_wdata),
    .rdata (sum_q)
  );

  assign busy      = (state_r != S_IDLE) || clr.active;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_node   = out_node_r;
  assign out_block  = out_block_r;

  // request checks at transfer time
  always_comb begin
    node_lim = (node_count_r < bba_pkg::NCNT_W'(bba_pkg::NODES)) ?
               node_count_r : bba_pkg::NCNT_W'(bba_pkg::NODES);
    node_ok  = bba_pkg::NCNT_W'(in_node) < node_lim;
    if (in_op == bba_pkg::OP_ALLOC) begin
      grp_nxt = in_group;
      wrd_nxt = '0;
      in_bad  = !node_ok || (int'(in_group) >= bba_pkg::GROUPS);
    end else begin
      grp_nxt = in_block[bba_pkg::BLOCK_W-1 -: bba_pkg::GROUP_W];
      wrd_nxt = in_block[bba_pkg::BIT_W +: bba_pkg::WIDX_W];
      in_bad  = !node_ok || (int'(grp_nxt) >= bba_pkg::GROUPS) ||
                (bba_pkg::BPN_W'(in_block) >= bpn_r);
    end
  end

  // words of the group that start below the usable limit
  always_comb begin
    gbase   = {1'b0, grp_r, {(bba_pkg::WIDX_W + bba_pkg::BIT_W){1'b0}}};
    rem     = (bpn_r > gbase) ? (bpn_r - gbase) : '0;
    nw_full = ((bba_pkg::BPN_W + 1)'(rem) + (bba_pkg::BPN_W + 1)'(bba_pkg::WORD_W - 1))
              >> bba_pkg::BIT_W;
    nwords  = (nw_full >= (bba_pkg::BPN_W + 1)'(bba_pkg::WORDS_PER_GROUP)) ?
              (bba_pkg::WIDX_W + 1)'(bba_pkg::WORDS_PER_GROUP) :
              nw_full[bba_pkg::WIDX_W:0];
    cand    = sum_q & bba_pkg::low_mask(nwords);
  end

  // usable bits of the chosen word
  always_comb begin
    wbase = {1'b0, grp_r, wrd_r, {bba_pkg::BIT_W{1'b0}}};
    left  = (bpn_r > wbase) ? (bpn_r - wbase) : '0;
    if (bpn_r <= wbase)
      umask = '0;
    else if (left >= bba_pkg::BPN_W'(bba_pkg::WORD_W))
      umask = '1;
    else
      umask = bba_pkg::low_mask(left[bba_pkg::BIT_W:0]);
    avail      = map_q & umask;
    alloc_bit  = bba_pkg::lowest_bit(avail);
    alloc_word = map_q & ~(bba_pkg::WORD_W'(1) << alloc_bit);
  end

  always_comb begin
    state_nxt = state_r;
    map_we    = 1'b0;
    sum_we    = 1'b0;
    map_addr  = {node_r, grp_r, wrd_r};
    sum_addr  = {node_r, grp_r};
    map_wdata = '1;
    sum_wdata = '1;
    res_vld   = 1'b0;
    res_stat  = bba_pkg::ST_BAD;
    res_block = '0;
    unique case (state_r)
      S_IDLE: begin
        if (clr.active) begin
          map_we   = 1'b1;
          map_addr = clr.addr;
          sum_we   = clr.addr < bba_pkg::MAP_AW'(bba_pkg::SUM_DEPTH);
          sum_addr = clr.addr[bba_pkg::SUM_AW-1:0];
        end else begin
          map_addr = {in_node, grp_nxt, wrd_nxt};
          sum_addr = {in_node, grp_nxt};
          if (accept) state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (bad_r) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
        end else if (op_r == bba_pkg::OP_FREE) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
          if (!map_q[bit_r]) begin
            map_we    = 1'b1;
            sum_we    = 1'b1;
            map_wdata = map_q | (bba_pkg::WORD_W'(1) << bit_r);
            sum_wdata = sum_q | (bba_pkg::WORDS_PER_GROUP'(1) << wrd_r);
            res_stat  = bba_pkg::ST_OK;
            res_block = {grp_r, wrd_r, bit_r};
          end
        end else if (cand == '0) begin
          res_vld   = 1'b1;
          res_stat  = bba_pkg::ST_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          map_addr  = {node_r, grp_r, bba_pkg::lowest_bit(cand)};
          state_nxt = S_WORD;
        end
      end
      S_WORD: begin
        res_vld   = 1'b1;
        state_nxt = S_IDLE;
        if (avail == '0) begin
          // only the boundary word can be partly usable; nothing past it is
          res_stat = bba_pkg::ST_EMPTY;
        end else begin
          map_we    = 1'b1;
          sum_we    = 1'b1;
          map_wdata = alloc_word;
          sum_wdata = sum_keep_r;
          sum_wdata[wrd_r] = |alloc_word;
          res_stat  = bba_pkg::ST_OK;
          res_block = {grp_r, wrd_r, alloc_bit};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= bba_pkg::NODE_COUNT_RST;
      bpn_r        <= bba_pkg::BLOCKS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_vld;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bba_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data[bba_pkg::NCNT_W-1:0];
          bba_pkg::CFG_BLOCKS:     bpn_r        <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      bad_r  <= in_bad;
      node_r <= in_node;
      grp_r  <= grp_nxt;
      wrd_r  <= wrd_nxt;
      bit_r  <= in_block[bba_pkg::BIT_W-1:0];
    end
    if (state_r == S_SUM) begin
      sum_keep_r <= sum_q;
      if (op_r == bba_pkg::OP_ALLOC) wrd_r <= bba_pkg::lowest_bit(cand);
    end
    if (res_vld) begin
      out_status_r <= res_stat;
      out_node_r   <= node_r;
      out_block_r  <= res_block;
    end
  end

endmodule

/* rtl/bba_ram.sv */
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bba_init.sv */
`timescale 1ns / 1ps

module bba_init (
  input  logic          clk,
  input  logic          rst_n,
  output bba_pkg::clr_t clr
);

  logic [bba_pkg::MAP_AW-1:0] cnt_r;
  logic                       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (!done_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == bba_pkg::MAP_AW'(bba_pkg::MAP_DEPTH - 1)) done_r <= 1'b1;
    end
  end

  // active flag above the clearing address
  assign clr = {!done_r, cnt_r};

endmodule
